/* rtl/rif_pkg.sv */
// Shared types, constants and the flux micro-program of the Rusanov interface flux block.
package rif_pkg;

  localparam int WORD_W   = 63;
  localparam int ADDR_W   = 5;
  localparam int RF_DEPTH = 32;
  localparam int PC_W     = 7;
  localparam int IN_WORDS = 9;
  localparam int SEL_W    = 4;
  localparam int OUT_N    = 7;
  localparam int OUT_W    = 48;
  localparam int PROD_W   = 124;
  localparam int HALF_W   = 31;

  localparam logic [PC_W-1:0] PROG_LAST = 7'd102;
  localparam logic [SEL_W-1:0] LOAD_LAST = 4'd8;
  localparam logic [ADDR_W-1:0] RIGHT_BASE = 5'd9;

  localparam logic signed [WORD_W-1:0] WIDE_MAX = 63'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [WORD_W-1:0] OUT_MAX  = 63'sd140737488355327;
  localparam logic signed [WORD_W-1:0] OUT_MIN  = -63'sd140737488355328;

  // Register file map: left state, right state, then temporaries.
  localparam logic [ADDR_W-1:0] A_RL = 5'd0;
  localparam logic [ADDR_W-1:0] A_UL = 5'd1;
  localparam logic [ADDR_W-1:0] A_VL = 5'd2;
  localparam logic [ADDR_W-1:0] A_EL = 5'd3;
  localparam logic [ADDR_W-1:0] A_PL = 5'd4;
  localparam logic [ADDR_W-1:0] A_CL = 5'd5;
  localparam logic [ADDR_W-1:0] A_HL = 5'd6;
  localparam logic [ADDR_W-1:0] A_OL = 5'd7;
  localparam logic [ADDR_W-1:0] A_WL = 5'd8;
  localparam logic [ADDR_W-1:0] A_RR = 5'd9;
  localparam logic [ADDR_W-1:0] A_UR = 5'd10;
  localparam logic [ADDR_W-1:0] A_VR = 5'd11;
  localparam logic [ADDR_W-1:0] A_ER = 5'd12;
  localparam logic [ADDR_W-1:0] A_PR = 5'd13;
  localparam logic [ADDR_W-1:0] A_CR = 5'd14;
  localparam logic [ADDR_W-1:0] A_HR = 5'd15;
  localparam logic [ADDR_W-1:0] A_OR = 5'd16;
  localparam logic [ADDR_W-1:0] A_WR = 5'd17;
  localparam logic [ADDR_W-1:0] A_ZR = 5'd18;
  localparam logic [ADDR_W-1:0] A_QL = 5'd19;
  localparam logic [ADDR_W-1:0] A_QR = 5'd20;
  localparam logic [ADDR_W-1:0] A_ML = 5'd21;
  localparam logic [ADDR_W-1:0] A_MR = 5'd22;
  localparam logic [ADDR_W-1:0] A_CM = 5'd23;
  localparam logic [ADDR_W-1:0] A_S1 = 5'd24;
  localparam logic [ADDR_W-1:0] A_S2 = 5'd25;
  localparam logic [ADDR_W-1:0] A_FL = 5'd26;
  localparam logic [ADDR_W-1:0] A_FR = 5'd27;
  localparam logic [ADDR_W-1:0] A_GL = 5'd28;
  localparam logic [ADDR_W-1:0] A_GR = 5'd29;
  localparam logic [ADDR_W-1:0] A_T  = 5'd30;

  localparam logic [ADDR_W-1:0] O_MASS = 5'd0;
  localparam logic [ADDR_W-1:0] O_MX   = 5'd1;
  localparam logic [ADDR_W-1:0] O_MY   = 5'd2;
  localparam logic [ADDR_W-1:0] O_EN   = 5'd3;
  localparam logic [ADDR_W-1:0] O_H2   = 5'd4;
  localparam logic [ADDR_W-1:0] O_O2   = 5'd5;
  localparam logic [ADDR_W-1:0] O_H2O  = 5'd6;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_HLF, OP_ABS, OP_MAX, OP_MUL, OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    WR_ZERO, WR_IN, WR_ALU, WR_MUL
  } wr_src_e;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_FETCH, ST_EXEC, ST_MUL, ST_MWB
  } state_e;

  // Each source has one address for an x normal and one for a y normal.
  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] a0;
    logic [ADDR_W-1:0] a1;
    logic [ADDR_W-1:0] b0;
    logic [ADDR_W-1:0] b1;
  } instr_t;

  typedef struct packed {
    logic              cap;
    logic              wr_en;
    wr_src_e           wr_src;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_a;
    logic [ADDR_W-1:0] rd_b;
    logic [SEL_W-1:0]  in_sel;
    op_e               op;
    logic              mul_load;
    logic              mul_step_en;
    logic [1:0]        mul_step;
    logic              out_en;
    logic [2:0]        out_idx;
  } ctrl_t;

  function automatic instr_t mk(op_e op, logic [ADDR_W-1:0] d, logic [ADDR_W-1:0] a0,
                                logic [ADDR_W-1:0] a1, logic [ADDR_W-1:0] b0,
                                logic [ADDR_W-1:0] b1);
    instr_t r;
    r.op = op;
    r.dst = d;
    r.a0 = a0;
    r.a1 = a1;
    r.b0 = b0;
    r.b1 = b1;
    return r;
  endfunction

  function automatic instr_t m2(op_e op, logic [ADDR_W-1:0] d, logic [ADDR_W-1:0] a,
                                logic [ADDR_W-1:0] b);
    return mk(op, d, a, a, b, b);
  endfunction

  // Six steps of half(fl + fr) - half(cmax * (ur - ul)), then the output write.
  function automatic instr_t rus_step(logic [2:0] j, logic [ADDR_W-1:0] fl,
                                      logic [ADDR_W-1:0] fr, logic [ADDR_W-1:0] ul,
                                      logic [ADDR_W-1:0] ur, logic [ADDR_W-1:0] k);
    instr_t r;
    case (j)
      3'd0:    r = m2(OP_ADD, A_S1, fl, fr);
      3'd1:    r = m2(OP_SUB, A_S2, ur, ul);
      3'd2:    r = m2(OP_MUL, A_S2, A_CM, A_S2);
      3'd3:    r = m2(OP_HLF, A_S1, A_S1, A_S1);
      3'd4:    r = m2(OP_HLF, A_S2, A_S2, A_S2);
      3'd5:    r = m2(OP_SUB, A_S1, A_S1, A_S2);
      default: r = m2(OP_OUT, k, A_S1, A_S1);
    endcase
    return r;
  endfunction

  function automatic instr_t prog(logic [PC_W-1:0] pc);
    instr_t r;
    case (pc)
      7'd0:  r = m2(OP_SUB, A_ZR, A_RL, A_RL);
      7'd1:  r = mk(OP_ADD, A_QL, A_UL, A_VL, A_ZR, A_ZR);
      7'd2:  r = mk(OP_ADD, A_QR, A_UR, A_VR, A_ZR, A_ZR);
      7'd3:  r = m2(OP_ABS, A_ML, A_QL, A_QL);
      7'd4:  r = m2(OP_ADD, A_ML, A_ML, A_CL);
      7'd5:  r = m2(OP_ABS, A_MR, A_QR, A_QR);
      7'd6:  r = m2(OP_ADD, A_MR, A_MR, A_CR);
      7'd7:  r = m2(OP_MAX, A_CM, A_ML, A_MR);
      7'd8:  r = m2(OP_MUL, A_FL, A_RL, A_QL);
      7'd9:  r = m2(OP_MUL, A_FR, A_RR, A_QR);
      7'd10, 7'd11, 7'd12, 7'd13, 7'd14, 7'd15, 7'd16:
        r = rus_step(3'(pc - 7'd10), A_FL, A_FR, A_RL, A_RR, O_MASS);
      7'd17: r = m2(OP_MUL, A_GL, A_RL, A_UL);
      7'd18: r = m2(OP_MUL, A_GR, A_RR, A_UR);
      7'd19: r = m2(OP_MUL, A_FL, A_GL, A_QL);
      7'd20: r = mk(OP_ADD, A_FL, A_FL, A_FL, A_PL, A_ZR);
      7'd21: r = m2(OP_MUL, A_FR, A_GR, A_QR);
      7'd22: r = mk(OP_ADD, A_FR, A_FR, A_FR, A_PR, A_ZR);
      7'd23, 7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29:
        r = rus_step(3'(pc - 7'd23), A_FL, A_FR, A_GL, A_GR, O_MX);
      7'd30: r = m2(OP_MUL, A_GL, A_RL, A_VL);
      7'd31: r = m2(OP_MUL, A_GR, A_RR, A_VR);
      7'd32: r = m2(OP_MUL, A_FL, A_GL, A_QL);
      7'd33: r = mk(OP_ADD, A_FL, A_FL, A_FL, A_ZR, A_PL);
      7'd34: r = m2(OP_MUL, A_FR, A_GR, A_QR);
      7'd35: r = mk(OP_ADD, A_FR, A_FR, A_FR, A_ZR, A_PR);
      7'd36, 7'd37, 7'd38, 7'd39, 7'd40, 7'd41, 7'd42:
        r = rus_step(3'(pc - 7'd36), A_FL, A_FR, A_GL, A_GR, O_MY);
      7'd43: r = m2(OP_MUL, A_GL, A_UL, A_UL);
      7'd44: r = m2(OP_MUL, A_T, A_VL, A_VL);
      7'd45: r = m2(OP_ADD, A_GL, A_GL, A_T);
      7'd46: r = m2(OP_HLF, A_GL, A_GL, A_GL);
      7'd47: r = m2(OP_ADD, A_GL, A_EL, A_GL);
      7'd48: r = m2(OP_MUL, A_GR, A_UR, A_UR);
      7'd49: r = m2(OP_MUL, A_T, A_VR, A_VR);
      7'd50: r = m2(OP_ADD, A_GR, A_GR, A_T);
      7'd51: r = m2(OP_HLF, A_GR, A_GR, A_GR);
      7'd52: r = m2(OP_ADD, A_GR, A_ER, A_GR);
      7'd53: r = m2(OP_MUL, A_FL, A_RL, A_QL);
      7'd54: r = m2(OP_MUL, A_FL, A_FL, A_GL);
      7'd55: r = m2(OP_MUL, A_T, A_QL, A_PL);
      7'd56: r = m2(OP_ADD, A_FL, A_FL, A_T);
      7'd57: r = m2(OP_MUL, A_FR, A_RR, A_QR);
      7'd58: r = m2(OP_MUL, A_FR, A_FR, A_GR);
      7'd59: r = m2(OP_MUL, A_T, A_QR, A_PR);
      7'd60: r = m2(OP_ADD, A_FR, A_FR, A_T);
      7'd61: r = m2(OP_MUL, A_GL, A_RL, A_GL);
      7'd62: r = m2(OP_MUL, A_GR, A_RR, A_GR);
      7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69:
        r = rus_step(3'(pc - 7'd63), A_FL, A_FR, A_GL, A_GR, O_EN);
      7'd70: r = m2(OP_MUL, A_GL, A_RL, A_HL);
      7'd71: r = m2(OP_MUL, A_GR, A_RR, A_HR);
      7'd72: r = m2(OP_MUL, A_FL, A_GL, A_QL);
      7'd73: r = m2(OP_MUL, A_FR, A_GR, A_QR);
      7'd74, 7'd75, 7'd76, 7'd77, 7'd78, 7'd79, 7'd80:
        r = rus_step(3'(pc - 7'd74), A_FL, A_FR, A_GL, A_GR, O_H2);
      7'd81: r = m2(OP_MUL, A_GL, A_RL, A_OL);
      7'd82: r = m2(OP_MUL, A_GR, A_RR, A_OR);
      7'd83: r = m2(OP_MUL, A_FL, A_GL, A_QL);
      7'd84: r = m2(OP_MUL, A_FR, A_GR, A_QR);
      7'd85, 7'd86, 7'd87, 7'd88, 7'd89, 7'd90, 7'd91:
        r = rus_step(3'(pc - 7'd85), A_FL, A_FR, A_GL, A_GR, O_O2);
      7'd92: r = m2(OP_MUL, A_GL, A_RL, A_WL);
      7'd93: r = m2(OP_MUL, A_GR, A_RR, A_WR);
      7'd94: r = m2(OP_MUL, A_FL, A_GL, A_QL);
      7'd95: r = m2(OP_MUL, A_FR, A_GR, A_QR);
      default:
        r = rus_step(3'(pc - 7'd96), A_FL, A_FR, A_GL, A_GR, O_H2O);
    endcase
    return r;
  endfunction

  function automatic logic signed [WORD_W-1:0] clampw(logic signed [WORD_W:0] x);
    logic signed [WORD_W:0]   lim;
    logic signed [WORD_W-1:0] r;
    lim = {WIDE_MAX[WORD_W-1], WIDE_MAX};
    if (x > lim) begin
      r = WIDE_MAX;
    end else if (x < -lim) begin
      r = -WIDE_MAX;
    end else begin
      r = x[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/rif_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
module rif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* rtl/rif_datapath.sv */
// Datapath: operand register file, clamped ALU, shared multi-cycle multiplier and result registers.
module rif_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  rif_pkg::ctrl_t        cmd_i,
  input  logic [30:0]           density_i,
  input  logic signed [31:0]    velocity_x_i,
  input  logic signed [31:0]    velocity_y_i,
  input  logic signed [31:0]    internal_energy_i,
  input  logic [30:0]           pressure_i,
  input  logic [30:0]           sound_speed_i,
  input  logic [16:0]           frac_h2_i,
  input  logic [16:0]           frac_o2_i,
  input  logic [16:0]           frac_h2o_i,
  output logic signed [rif_pkg::OUT_W-1:0] flux_o [rif_pkg::OUT_N]
);

  localparam int W = rif_pkg::WORD_W;

  logic signed [W-1:0] in_q [rif_pkg::IN_WORDS];
  logic signed [W-1:0] rd_a, rd_b, wdata, alu_res, mul_res;
  logic [W-2:0] ma_q, mb_q;
  logic neg_q;
  logic [rif_pkg::PROD_W-1:0] acc_q, pp_sh, shr;
  logic [rif_pkg::HALF_W-1:0] ah, bh;
  logic [2*rif_pkg::HALF_W-1:0] pp;
  logic signed [W-1:0] a_abs, b_abs, mag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      in_q[0] <= W'(density_i);
      in_q[1] <= W'(velocity_x_i);
      in_q[2] <= W'(velocity_y_i);
      in_q[3] <= W'(internal_energy_i);
      in_q[4] <= W'(pressure_i);
      in_q[5] <= W'(sound_speed_i);
      in_q[6] <= W'(frac_h2_i);
      in_q[7] <= W'(frac_o2_i);
      in_q[8] <= W'(frac_h2o_i);
    end
  end

  rif_ram #(.WIDTH(W), .DEPTH(rif_pkg::RF_DEPTH)) u_rf (
    .clk_i     (clk_i),
    .we_i      (cmd_i.wr_en),
    .waddr_i   (cmd_i.wr_addr),
    .wdata_i   (wdata),
    .raddr_a_i (cmd_i.rd_a),
    .raddr_b_i (cmd_i.rd_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign a_abs = rd_a[W-1] ? -rd_a : rd_a;
  assign b_abs = rd_b[W-1] ? -rd_b : rd_b;

  always_comb begin
    case (cmd_i.op)
      rif_pkg::OP_ADD: alu_res = rif_pkg::clampw({rd_a[W-1], rd_a} + {rd_b[W-1], rd_b});
      rif_pkg::OP_SUB: alu_res = rif_pkg::clampw({rd_a[W-1], rd_a} - {rd_b[W-1], rd_b});
      rif_pkg::OP_HLF: alu_res = (rd_a + $signed(W'(rd_a[W-1]))) >>> 1;
      rif_pkg::OP_ABS: alu_res = a_abs;
      rif_pkg::OP_MAX: alu_res = (rd_a >= rd_b) ? rd_a : rd_b;
      default:         alu_res = rd_a;
    endcase
  end

  // One 31 x 31 partial product per step, four steps per product.
  assign ah = cmd_i.mul_step[1] ? ma_q[W-2:rif_pkg::HALF_W] : ma_q[rif_pkg::HALF_W-1:0];
  assign bh = cmd_i.mul_step[0] ? mb_q[W-2:rif_pkg::HALF_W] : mb_q[rif_pkg::HALF_W-1:0];
  assign pp = (2*rif_pkg::HALF_W)'(ah) * (2*rif_pkg::HALF_W)'(bh);

  always_comb begin
    case ({1'b0, cmd_i.mul_step[1]} + {1'b0, cmd_i.mul_step[0]})
      2'd0:    pp_sh = rif_pkg::PROD_W'(pp);
      2'd1:    pp_sh = rif_pkg::PROD_W'(pp) << rif_pkg::HALF_W;
      default: pp_sh = rif_pkg::PROD_W'(pp) << (2*rif_pkg::HALF_W);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      ma_q  <= a_abs[W-2:0];
      mb_q  <= b_abs[W-2:0];
      neg_q <= rd_a[W-1] ^ rd_b[W-1];
      acc_q <= '0;
    end else if (cmd_i.mul_step_en) begin
      acc_q <= acc_q + pp_sh;
    end
  end

  assign shr = acc_q >> FRAC_BITS;
  assign mag = (shr > rif_pkg::PROD_W'(rif_pkg::WIDE_MAX)) ? rif_pkg::WIDE_MAX : shr[W-1:0];
  assign mul_res = neg_q ? -mag : mag;

  always_comb begin
    case (cmd_i.wr_src)
      rif_pkg::WR_ZERO: wdata = '0;
      rif_pkg::WR_IN:   wdata = in_q[cmd_i.in_sel];
      rif_pkg::WR_ALU:  wdata = alu_res;
      default:          wdata = mul_res;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_en) begin
      if (rd_a > rif_pkg::OUT_MAX) begin
        flux_o[cmd_i.out_idx] <= rif_pkg::OUT_MAX[rif_pkg::OUT_W-1:0];
      end else if (rd_a < rif_pkg::OUT_MIN) begin
        flux_o[cmd_i.out_idx] <= rif_pkg::OUT_MIN[rif_pkg::OUT_W-1:0];
      end else begin
        flux_o[cmd_i.out_idx] <= rd_a[rif_pkg::OUT_W-1:0];
      end
    end
  end

endmodule

/* rtl/rif_ctrl.sv */
// Controller: clearing pass, state load and micro-program sequencer.
module rif_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           func_i,
  output logic           busy,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i,
  output rif_pkg::ctrl_t cmd_o,
  output logic           strobe_o
);

  rif_pkg::state_e state_q, state_d;
  logic [rif_pkg::PC_W-1:0]  pc_q, pc_d;
  logic [rif_pkg::SEL_W-1:0] cnt_q, cnt_d;
  logic func_q, func_d, axis_q, strobe_q, strobe_d;
  rif_pkg::instr_t ins;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != rif_pkg::ST_IDLE);
  assign strobe_o    = strobe_q;
  assign ins         = rif_pkg::prog(pc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rif_pkg::ST_CLEAR;
      pc_q     <= '0;
      cnt_q    <= '0;
      func_q   <= 1'b0;
      axis_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      cnt_q    <= cnt_d;
      func_q   <= func_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        axis_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    cnt_d    = cnt_q;
    func_d   = func_q;
    strobe_d = 1'b0;

    cmd_o             = '0;
    cmd_o.wr_src      = rif_pkg::WR_ALU;
    cmd_o.op          = ins.op;
    cmd_o.rd_a        = axis_q ? ins.a1 : ins.a0;
    cmd_o.rd_b        = axis_q ? ins.b1 : ins.b0;
    cmd_o.wr_addr     = ins.dst;
    cmd_o.in_sel      = cnt_q;
    cmd_o.mul_step    = cnt_q[1:0];
    cmd_o.out_idx     = ins.dst[2:0];

    case (state_q)
      rif_pkg::ST_CLEAR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_src  = rif_pkg::WR_ZERO;
        cmd_o.wr_addr = rif_pkg::ADDR_W'(cnt_q);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == rif_pkg::LOAD_LAST) begin
          cnt_d   = '0;
          state_d = rif_pkg::ST_IDLE;
        end
      end
      rif_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.cap = 1'b1;
          func_d    = func_i;
          cnt_d     = '0;
          state_d   = rif_pkg::ST_LOAD;
        end
      end
      rif_pkg::ST_LOAD: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_src  = rif_pkg::WR_IN;
        cmd_o.wr_addr = (func_q ? rif_pkg::RIGHT_BASE : '0) + rif_pkg::ADDR_W'(cnt_q);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == rif_pkg::LOAD_LAST) begin
          cnt_d   = '0;
          pc_d    = '0;
          state_d = func_q ? rif_pkg::ST_FETCH : rif_pkg::ST_IDLE;
        end
      end
      rif_pkg::ST_FETCH: begin
        state_d = rif_pkg::ST_EXEC;
      end
      rif_pkg::ST_EXEC: begin
        case (ins.op)
          rif_pkg::OP_MUL: begin
            cmd_o.mul_load = 1'b1;
            cnt_d   = '0;
            state_d = rif_pkg::ST_MUL;
          end
          rif_pkg::OP_OUT: begin
            cmd_o.out_en = 1'b1;
            if (pc_q == rif_pkg::PROG_LAST) begin
              strobe_d = 1'b1;
              state_d  = rif_pkg::ST_IDLE;
            end else begin
              pc_d    = pc_q + 1'b1;
              state_d = rif_pkg::ST_FETCH;
            end
          end
          default: begin
            cmd_o.wr_en = 1'b1;
            pc_d    = pc_q + 1'b1;
            state_d = rif_pkg::ST_FETCH;
          end
        endcase
      end
      rif_pkg::ST_MUL: begin
        cmd_o.mul_step_en = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[1:0] == 2'd3) begin
          state_d = rif_pkg::ST_MWB;
        end
      end
      rif_pkg::ST_MWB: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = rif_pkg::WR_MUL;
        pc_d    = pc_q + 1'b1;
        state_d = rif_pkg::ST_FETCH;
      end
      default: begin
        state_d = rif_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/rusanov_interface_flux_top.sv */
// Top level of the Rusanov (local Lax-Friedrichs) interface flux block.
// The block computes seven face fluxes of a two-dimensional, three-species flow.
// An input beat is taken when start is high and busy is low. A beat with func_i low
// stores the left face state; a beat with func_i high carries the right state and
// starts the flux computation. A left beat occupies the block while the nine
// words are copied into the operand register file.
// A right beat first loads its nine words, then runs a micro-program of 103
// operations, each fetched and then executed; the 41 products also pass through
// the multiply steps and a write-back on the single shared 31 by 31 bit multiplier.
// It and the one register-file write port set the rate; one face pair is in flight.
// The result beat is shown for exactly one cycle with strobe_o high; the receiver
// cannot stall it, and a new start may be given in that same cycle.
// The configuration channel (cfg_valid_i, cfg_ready_o, cfg_data_i) sets the face
// normal: 0 for x, 1 for y. It is always ready and should only be written while
// the block is idle.
// After reset a clearing pass zeroes the stored left state, with busy high
// during it. The normal resets to x.
module rusanov_interface_flux_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               func_i,
  input  logic [30:0]        density_i,
  input  logic signed [31:0] velocity_x_i,
  input  logic signed [31:0] velocity_y_i,
  input  logic signed [31:0] internal_energy_i,
  input  logic [30:0]        pressure_i,
  input  logic [30:0]        sound_speed_i,
  input  logic [16:0]        frac_h2_i,
  input  logic [16:0]        frac_o2_i,
  input  logic [16:0]        frac_h2o_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  output logic               strobe_o,
  output logic signed [47:0] mass_flux_o,
  output logic signed [47:0] momentum_x_flux_o,
  output logic signed [47:0] momentum_y_flux_o,
  output logic signed [47:0] energy_flux_o,
  output logic signed [47:0] hydrogen_flux_o,
  output logic signed [47:0] oxygen_flux_o,
  output logic signed [47:0] water_flux_o
);

  rif_pkg::ctrl_t cmd;
  logic signed [rif_pkg::OUT_W-1:0] flux [rif_pkg::OUT_N];

  // The controller sequences the micro-program and owns the normal register.
  rif_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .func_i      (func_i),
    .busy        (busy),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .strobe_o    (strobe_o)
  );

  // The datapath holds operands, the ALU, the multiplier and the result registers.
  rif_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .density_i         (density_i),
    .velocity_x_i      (velocity_x_i),
    .velocity_y_i      (velocity_y_i),
    .internal_energy_i (internal_energy_i),
    .pressure_i        (pressure_i),
    .sound_speed_i     (sound_speed_i),
    .frac_h2_i         (frac_h2_i),
    .frac_o2_i         (frac_o2_i),
    .frac_h2o_i        (frac_h2o_i),
    .flux_o            (flux)
  );

  assign mass_flux_o       = flux[0];
  assign momentum_x_flux_o = flux[1];
  assign momentum_y_flux_o = flux[2];
  assign energy_flux_o     = flux[3];
  assign hydrogen_flux_o   = flux[4];
  assign oxygen_flux_o     = flux[5];
  assign water_flux_o      = flux[6];

`ifndef ASSERT_OFF
  // A result is only ever presented once the sequencer has returned to idle.
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy) else $error("result strobe while busy");

  // Two results can never be back to back.
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o) else $error("repeated result strobe");

  // An accepted beat always occupies the block in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !strobe_o)) else $error("accepted beat not taken up");
`endif

endmodule
